/* rtl/core/tgc_pkg.sv */
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types and constants of the touch gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

    localparam int COORD_BITS = 12;
    localparam int COUNT_BITS = 4;
    localparam int DIST_BITS  = COORD_BITS + 1;
    localparam int HOLD_BITS  = 17;
    localparam int TICK_BITS  = 16;
    localparam int RAD_BITS   = 8;

    localparam int GESTURE_BITS  = 3;
    localparam int IN_FIELD_BITS = COUNT_BITS + 2 * COORD_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((GESTURE_BITS + 7) / 8) * 8;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_LONG_PRESS = 2'd0;
    localparam logic [1:0] REG_DTAP_GAP   = 2'd1;
    localparam logic [1:0] REG_STILL_RAD  = 2'd2;
    localparam logic [1:0] REG_DTAP_RAD   = 2'd3;

    localparam logic [TICK_BITS-1:0] LONG_PRESS_RESET = 16'd30;
    localparam logic [TICK_BITS-1:0] DTAP_GAP_RESET   = 16'd15;
    localparam logic [RAD_BITS-1:0]  STILL_RAD_RESET  = 8'd2;
    localparam logic [RAD_BITS-1:0]  DTAP_RAD_RESET   = 8'd5;

    typedef enum logic [GESTURE_BITS-1:0] {
        G_IDLE = 3'd0,
        G_DOWN = 3'd1,
        G_UP   = 3'd2,
        G_TAP  = 3'd3,
        G_LONG = 3'd4,
        G_DTAP = 3'd5
    } gesture_t;

    typedef struct packed {
        logic [TICK_BITS-1:0] long_press_ticks;
        logic [TICK_BITS-1:0] double_tap_gap_ticks;
        logic [RAD_BITS-1:0]  still_radius;
        logic [RAD_BITS-1:0]  double_tap_radius;
    } cfg_t;

    // Distance verdicts against the anchor point
    typedef struct packed {
        logic still;
        logic near_tap;
    } dist_flags_t;

endpackage

/* rtl/core/touch_gesture_classifier.sv */
// ----------------------------------------------------------------------------
// touch_gesture_classifier
// Tap, long-press and double-tap detector over a stream of touch frames.
// ----------------------------------------------------------------------------
// One touch frame goes in per request and exactly one gesture code comes out
// (0 idle, 1 down, 2 up, 3 tap, 4 long press, 5 double tap). The block takes a
// new frame every clock cycle while the result is not held up by the sink; the
// input register holds the frame, the decision logic runs from it and the
// result register captures the gesture when it is free or being drained.
// While a finished gesture waits for the sink, one more frame is still taken
// into an empty input register; beyond that the input stalls until the sink
// takes the result. Touch state (hold and gap counters, anchor, previous
// gesture and point count) lives across frames and is only cleared by reset.
// Write the four thresholds over the register port while no frame is in
// flight.
// ----------------------------------------------------------------------------
module touch_gesture_classifier
    import tgc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    // Frame input
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // point_count [COUNT_BITS], point_x [COORD_BITS], point_y [COORD_BITS], zero pad
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    // recalc
    input  logic                     s_tuser,

    // Gesture output
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // gesture [3], zero pad
    output logic [OUT_DATA_BITS-1:0] m_tdata,

    // Register port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int PX_LO = COUNT_BITS;
    localparam int PY_LO = COUNT_BITS + COORD_BITS;

    cfg_t                  cfg_reg, cfg_next;
    logic [1:0]            reg_idx;
    logic                  cfg_write;

    logic                  in_valid_reg, in_valid_next;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COORD_BITS-1:0] px_reg;
    logic [COORD_BITS-1:0] py_reg;
    logic                  recalc_reg;

    logic                  out_valid_reg, out_valid_next;
    gesture_t              gesture_reg;
    gesture_t              gesture;

    logic                  s_take;
    logic                  advance;

    // ---------------- register port ----------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_idx)
                REG_LONG_PRESS: cfg_next.long_press_ticks     = pwdata[TICK_BITS-1:0];
                REG_DTAP_GAP:   cfg_next.double_tap_gap_ticks = pwdata[TICK_BITS-1:0];
                REG_STILL_RAD:  cfg_next.still_radius         = pwdata[RAD_BITS-1:0];
                REG_DTAP_RAD:   cfg_next.double_tap_radius    = pwdata[RAD_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LONG_PRESS: prdata = APB_DATA_BITS'(cfg_reg.long_press_ticks);
            REG_DTAP_GAP:   prdata = APB_DATA_BITS'(cfg_reg.double_tap_gap_ticks);
            REG_STILL_RAD:  prdata = APB_DATA_BITS'(cfg_reg.still_radius);
            REG_DTAP_RAD:   prdata = APB_DATA_BITS'(cfg_reg.double_tap_radius);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks     <= LONG_PRESS_RESET;
            cfg_reg.double_tap_gap_ticks <= DTAP_GAP_RESET;
            cfg_reg.still_radius         <= STILL_RAD_RESET;
            cfg_reg.double_tap_radius    <= DTAP_RAD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- frame pipeline ----------------
    // Advance the held frame whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on take, hold otherwise
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            cnt_reg    <= s_tdata[COUNT_BITS-1:0];
            px_reg     <= s_tdata[PX_LO +: COORD_BITS];
            py_reg     <= s_tdata[PY_LO +: COORD_BITS];
            recalc_reg <= s_tuser;
        end
        if (advance)
        begin
            gesture_reg <= gesture;
        end
    end

    tgc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .commit      (advance),
        .point_count (cnt_reg),
        .point_x     (px_reg),
        .point_y     (py_reg),
        .recalc      (recalc_reg),
        .cfg         (cfg_reg),
        .gesture     (gesture)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_BITS'(gesture_reg);

    // Every decided frame shows up as a result in the next cycle
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("decided frame produced no result");

    // Back-pressure only when a frame is parked and the result is stuck
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[GESTURE_BITS-1:0] <= GESTURE_BITS'(G_DTAP)))
        else $error("gesture code out of range");

endmodule

/* rtl/core/tgc_dist.sv */
// ----------------------------------------------------------------------------
// tgc_dist
// Manhattan distance from the anchor point and the two radius compares.
// ----------------------------------------------------------------------------
module tgc_dist
    import tgc_pkg::*;
(
    input  logic [COORD_BITS-1:0] anchor_x,
    input  logic [COORD_BITS-1:0] anchor_y,
    input  logic [COORD_BITS-1:0] point_x,
    input  logic [COORD_BITS-1:0] point_y,
    input  logic [RAD_BITS-1:0]   still_radius,
    input  logic [RAD_BITS-1:0]   double_tap_radius,
    output dist_flags_t           flags
);

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [DIST_BITS-1:0]  manhattan;

    assign dx        = (anchor_x > point_x) ? (anchor_x - point_x) : (point_x - anchor_x);
    assign dy        = (anchor_y > point_y) ? (anchor_y - point_y) : (point_y - anchor_y);
    assign manhattan = DIST_BITS'(dx) + DIST_BITS'(dy);

    assign flags.still    = (manhattan <= DIST_BITS'(still_radius));
    assign flags.near_tap = (manhattan <= DIST_BITS'(double_tap_radius));

endmodule

/* rtl/core/tgc_core.sv */
// ----------------------------------------------------------------------------
// tgc_core
// Gesture decision and touch state: hold and gap counters, anchor, history.
// ----------------------------------------------------------------------------
module tgc_core
    import tgc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  commit,
    input  logic [COUNT_BITS-1:0] point_count,
    input  logic [COORD_BITS-1:0] point_x,
    input  logic [COORD_BITS-1:0] point_y,
    input  logic                  recalc,
    input  cfg_t                  cfg,
    output gesture_t              gesture
);

    logic [HOLD_BITS-1:0]  hold_reg, hold_next;
    logic [HOLD_BITS-1:0]  gap_reg, gap_next;
    logic                  win_reg, win_next;
    logic [COORD_BITS-1:0] anchor_x_reg, anchor_x_next;
    logic [COORD_BITS-1:0] anchor_y_reg, anchor_y_next;
    gesture_t              last_reg, last_next;
    logic [COUNT_BITS-1:0] prev_cnt_reg, prev_cnt_next;

    dist_flags_t           dflags;
    logic                  release_path;
    logic                  hold_nz;
    logic                  tap;
    logic                  win_eff;
    logic [HOLD_BITS-1:0]  gap_eff;
    logic [HOLD_BITS-1:0]  sat;
    logic [HOLD_BITS-1:0]  gap_limit;
    logic                  window_live;

    tgc_dist u_dist (
        .anchor_x          (anchor_x_reg),
        .anchor_y          (anchor_y_reg),
        .point_x           (point_x),
        .point_y           (point_y),
        .still_radius      (cfg.still_radius),
        .double_tap_radius (cfg.double_tap_radius),
        .flags             (dflags)
    );

    assign release_path = (point_count != COUNT_BITS'(1)) || recalc;
    assign hold_nz      = (hold_reg != '0);
    assign sat          = HOLD_BITS'(cfg.long_press_ticks) + HOLD_BITS'(1);
    assign gap_limit    = HOLD_BITS'(cfg.double_tap_gap_ticks) + HOLD_BITS'(1);
    assign window_live  = win_reg && (gap_reg <= gap_limit);

    // A tap reopens the window with a fresh gap before the gap check runs
    assign tap     = release_path && hold_nz && (point_count <= COUNT_BITS'(1))
                     && (hold_reg < HOLD_BITS'(cfg.long_press_ticks));
    assign win_eff = win_reg || tap;
    assign gap_eff = tap ? '0 : gap_reg;

    always_comb
    begin
        hold_next     = hold_reg;
        gap_next      = gap_reg;
        win_next      = win_reg;
        anchor_x_next = anchor_x_reg;
        anchor_y_next = anchor_y_reg;
        last_next     = last_reg;
        prev_cnt_next = point_count;
        gesture       = G_IDLE;

        if (release_path)
        begin
            if (hold_nz && (point_count > COUNT_BITS'(1)))
            begin
                gesture = G_UP;
            end
            else if (tap)
            begin
                gesture = G_TAP;
            end
            last_next = gesture;
            hold_next = '0;
            if (win_eff && (gap_eff <= gap_limit) && (point_count == '0))
            begin
                win_next = 1'b1;
                gap_next = gap_eff + HOLD_BITS'(1);
            end
            else
            begin
                win_next = 1'b0;
                gap_next = gap_eff;
            end
        end
        else if (hold_nz)
        begin
            if (!dflags.still)
            begin
                gesture   = G_UP;
                last_next = G_UP;
                hold_next = '0;
            end
            else if (hold_reg >= HOLD_BITS'(cfg.long_press_ticks))
            begin
                if ((last_reg == G_LONG) || (last_reg == G_DTAP))
                begin
                    gesture = last_reg;
                end
                else
                begin
                    gesture   = G_LONG;
                    last_next = G_LONG;
                    hold_next = sat;
                end
            end
            else
            begin
                gesture   = G_DOWN;
                last_next = G_DOWN;
                hold_next = hold_reg + HOLD_BITS'(1);
            end
        end
        else if (prev_cnt_reg == '0)
        begin
            if (window_live && dflags.near_tap)
            begin
                gesture   = G_DTAP;
                hold_next = sat;
            end
            else
            begin
                gesture       = G_DOWN;
                hold_next     = HOLD_BITS'(1);
                anchor_x_next = point_x;
                anchor_y_next = point_y;
            end
            last_next = gesture;
            win_next  = 1'b0;
        end
        else
        begin
            gesture   = G_IDLE;
            last_next = G_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg     <= '0;
            gap_reg      <= '0;
            win_reg      <= 1'b0;
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
            last_reg     <= G_IDLE;
            prev_cnt_reg <= '0;
        end
        else if (commit)
        begin
            hold_reg     <= hold_next;
            gap_reg      <= gap_next;
            win_reg      <= win_next;
            anchor_x_reg <= anchor_x_next;
            anchor_y_reg <= anchor_y_next;
            last_reg     <= last_next;
            prev_cnt_reg <= prev_cnt_next;
        end
    end

    // An open tap window only survives empty frames with no touch held
    a_window_idle: assert property (@(posedge clk) disable iff (!rst_n)
        win_reg |-> ((prev_cnt_reg == '0) && (hold_reg == '0)))
        else $error("tap window open while a touch is present");

    a_dtap_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (gesture == G_DTAP)) |=> (hold_reg != '0) && !win_reg)
        else $error("double tap did not start a held touch");

    a_tap_opens: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && (gesture == G_TAP) && (point_count == '0)) |=> win_reg)
        else $error("tap on release did not open the window");

endmodule

/* dv/touch_gesture_classifier_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_gesture_classifier_tb
// Self-checking bench for the tap, long-press and double-tap classifier.
// ----------------------------------------------------------------------------
// Frames are queued by the stimulus process, then played into the frame
// stream by a clocked driver. The driver runs each accepted frame through a
// local gesture predictor and stores the predicted code. A clocked monitor
// pops the oldest prediction for each gesture leaving the block and compares
// the two. The run goes through several threshold settings, each written over
// the register port and read back while no frame is in flight. It also goes
// through several idling patterns on both stream sides.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_tb;
    import tgc_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_PHASES  = 5;
    localparam int RANDOM_ITEMS_PER_PHASE = 80;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int TAIL_CYCLES = 4;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  recalc;
    } touch_frame_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    // point_count [COUNT_BITS], point_x [COORD_BITS], point_y [COORD_BITS], zero pad
    logic [IN_DATA_BITS-1:0]  s_tdata;
    // recalc
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    // gesture [3], zero pad
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Frames waiting to be driven, and gestures predicted for accepted frames
    touch_frame_t frame_q[$];
    gesture_t     predicted_gestures[$];
    touch_frame_t cur_frame;

    // Idling pattern of the current phase, in percent
    int src_idle_pct;
    int sink_stall_pct;

    int err_count;
    int cycle_count;

    // Shadow copy of the thresholds and of the touch state
    cfg_t                  cfg_q;
    int                    hold_cnt;
    int                    gap_cnt;
    bit                    win_open;
    logic [COORD_BITS-1:0] anc_x;
    logic [COORD_BITS-1:0] anc_y;
    gesture_t              last_g;
    logic [COUNT_BITS-1:0] prev_cnt;

    touch_gesture_classifier dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Gesture predictor: advance the shadow touch state by one frame and
    // return the gesture the block must report for it.
    // ------------------------------------------------------------------------
    function automatic gesture_t classify_frame(touch_frame_t f);
        int       sat;
        int       gap_lim;
        int       manhattan;
        int       dx;
        int       dy;
        gesture_t g;
        sat       = int'(cfg_q.long_press_ticks) + 1;
        gap_lim   = int'(cfg_q.double_tap_gap_ticks) + 1;
        dx        = (f.x > anc_x) ? int'(f.x) - int'(anc_x) : int'(anc_x) - int'(f.x);
        dy        = (f.y > anc_y) ? int'(f.y) - int'(anc_y) : int'(anc_y) - int'(f.y);
        manhattan = dx + dy;
        g         = G_IDLE;
        if (f.count != 1 || f.recalc)
        begin
            // Release path: finger lifted, extra fingers, or forced recalc
            if (hold_cnt > 0)
            begin
                if (f.count > 1)
                begin
                    g = G_UP;
                end
                else if (hold_cnt < int'(cfg_q.long_press_ticks))
                begin
                    g        = G_TAP;
                    win_open = 1'b1;
                    gap_cnt  = 0;
                end
            end
            last_g   = g;
            hold_cnt = 0;
            // Keep the double-tap window counting only over empty frames
            if (win_open && gap_cnt <= gap_lim && f.count == 0)
                gap_cnt = (gap_cnt + 1) & 'h1FFFF;
            else
                win_open = 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            if (manhattan <= int'(cfg_q.still_radius))
            begin
                if (hold_cnt >= int'(cfg_q.long_press_ticks))
                begin
                    // Long press and double tap repeat while the finger stays
                    if (last_g == G_LONG || last_g == G_DTAP)
                    begin
                        g = last_g;
                    end
                    else
                    begin
                        g        = G_LONG;
                        last_g   = G_LONG;
                        hold_cnt = sat;
                    end
                end
                else
                begin
                    g        = G_DOWN;
                    last_g   = G_DOWN;
                    hold_cnt = hold_cnt + 1;
                end
            end
            else
            begin
                g        = G_UP;
                last_g   = G_UP;
                hold_cnt = 0;
            end
        end
        else if (prev_cnt == 0)
        begin
            // Fresh touch: double tap if close to the last tap in time and space
            if (win_open && gap_cnt <= gap_lim &&
                manhattan <= int'(cfg_q.double_tap_radius))
            begin
                g        = G_DTAP;
                hold_cnt = sat;
            end
            else
            begin
                g        = G_DOWN;
                hold_cnt = 1;
                anc_x    = f.x;
                anc_y    = f.y;
            end
            last_g   = g;
            win_open = 1'b0;
        end
        else
        begin
            // Single point after a non-empty frame with no touch held
            g      = G_IDLE;
            last_g = G_IDLE;
        end
        prev_cnt = f.count;
        return g;
    endfunction

    // ------------------------------------------------------------------------
    // Frame driver: hold a request until taken, then load the next frame or
    // idle at the phase rate. Predict each frame at the edge that takes it.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : frame_driver
        touch_frame_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predicted_gestures.push_back(classify_frame(cur_frame));
            if (!s_tvalid || s_tready)
            begin
                if (frame_q.size() > 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    nxt = frame_q.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {{(IN_DATA_BITS - IN_FIELD_BITS){1'b0}}, nxt.y, nxt.x,
                                  nxt.count};
                    s_tuser   <= nxt.recalc;
                    cur_frame <= nxt;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Gesture monitor: compare each gesture taken from the block with the
    // oldest prediction; stall the sink at the phase rate.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : gesture_monitor
        gesture_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_gestures.size() == 0)
                begin
                    $error("gesture: no request outstanding, actual %0d",
                           m_tdata[GESTURE_BITS-1:0]);
                    err_count++;
                end
                else
                begin
                    want = predicted_gestures.pop_front();
                    if (m_tdata[GESTURE_BITS-1:0] !== want)
                    begin
                        $error("gesture: expected %0d, actual %0d", want,
                               m_tdata[GESTURE_BITS-1:0]);
                        err_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: end the run once the total cycle limit is reached
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [APB_DATA_BITS-1:0] wdata,
                              output logic [APB_DATA_BITS-1:0] rdata);
        // Setup cycle, then access cycle until pready
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_cfg(input logic [1:0] idx, input int val);
        logic [APB_DATA_BITS-1:0] rd;
        logic [APB_DATA_BITS-1:0] want;
        want = APB_DATA_BITS'(val);
        apb_access(1'b1, idx, want, rd);
        case (idx)
            REG_LONG_PRESS: cfg_q.long_press_ticks     = want[TICK_BITS-1:0];
            REG_DTAP_GAP:   cfg_q.double_tap_gap_ticks = want[TICK_BITS-1:0];
            REG_STILL_RAD:  cfg_q.still_radius         = want[RAD_BITS-1:0];
            REG_DTAP_RAD:   cfg_q.double_tap_radius    = want[RAD_BITS-1:0];
            default: ;
        endcase
        // Read back what was just written
        apb_access(1'b0, idx, '0, rd);
        if (rd !== want)
        begin
            $error("register %0d: expected %0d, actual %0d", idx, want, rd);
            err_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building blocks
    // ------------------------------------------------------------------------
    task automatic push_frame(input int cnt, input int x, input int y, input bit rc);
        touch_frame_t f;
        f.count  = COUNT_BITS'(cnt);
        f.x      = COORD_BITS'(x);
        f.y      = COORD_BITS'(y);
        f.recalc = rc;
        frame_q.push_back(f);
    endtask

    // Move a coordinate by d, toward the side that has room
    function automatic int step_off(int base, int d);
        return (base + d <= COORD_MAX) ? base + d : base - d;
    endfunction

    // One point at Manhattan distance d from (bx, by)
    task automatic push_offset(input int bx, input int by, input int d);
        int dx;
        dx = $urandom_range(d);
        push_frame(1, step_off(bx, dx), step_off(by, d - dx), 0);
    endtask

    // n still frames, mostly inside the radius, now and then right on it
    task automatic push_hold(input int bx, input int by, input int n);
        int r;
        r = int'(cfg_q.still_radius);
        repeat (n)
        begin
            if ($urandom_range(3) == 0)
                push_offset(bx, by, r);
            else
                push_offset(bx, by, $urandom_range(r));
        end
    endtask

    task automatic push_empty();
        push_frame(0, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX), 0);
    endtask

    // One gesture-shaped run of frames with random content, or a bit of noise
    task automatic gen_sequence();
        int kind;
        int bx;
        int by;
        int n;
        int lp;
        int gap;
        bx   = $urandom_range(COORD_MAX);
        by   = $urandom_range(COORD_MAX);
        lp   = int'(cfg_q.long_press_ticks);
        gap  = int'(cfg_q.double_tap_gap_ticks);
        kind = $urandom_range(99);
        push_empty();
        if (kind < 20)
        begin
            // tap
            push_frame(1, bx, by, 0);
            push_hold(bx, by, $urandom_range(3));
            push_empty();
        end
        else if (kind < 40)
        begin
            // double tap attempt: tap, short gap, second touch near the first
            push_frame(1, bx, by, 0);
            push_hold(bx, by, $urandom_range(2));
            push_empty();
            n = (gap <= 4) ? $urandom_range(gap + 3) : $urandom_range(4);
            repeat (n) push_empty();
            push_offset(bx, by, $urandom_range(int'(cfg_q.double_tap_radius) + 1));
            push_hold(bx, by, $urandom_range(2));
            push_empty();
        end
        else if (kind < 55)
        begin
            // long press where the threshold allows it, else a short hold
            push_frame(1, bx, by, 0);
            if (lp <= 40)
                push_hold(bx, by, lp + $urandom_range(3));
            else
                push_hold(bx, by, $urandom_range(8));
            if ($urandom_range(1))
                push_empty();
            else
                push_frame($urandom_range(15, 2), bx, by, 0);
        end
        else if (kind < 65)
        begin
            // slide out of the still radius, then stray single points
            push_frame(1, bx, by, 0);
            push_hold(bx, by, $urandom_range(2));
            push_offset(bx, by, int'(cfg_q.still_radius) + 1 + $urandom_range(3));
            repeat ($urandom_range(2)) push_frame(1, bx, by, 0);
            push_empty();
        end
        else if (kind < 75)
        begin
            // second finger lands
            push_frame(1, bx, by, 0);
            push_hold(bx, by, $urandom_range(3));
            push_frame($urandom_range(15, 2), $urandom_range(COORD_MAX),
                       $urandom_range(COORD_MAX), 0);
            push_frame(1, bx, by, 0);
            push_empty();
        end
        else if (kind < 85)
        begin
            // forced recalc in the middle of a touch
            push_frame(1, bx, by, 0);
            push_hold(bx, by, $urandom_range(3));
            push_frame($urandom_range(15), bx, by, 1);
            push_empty();
        end
        else
        begin
            // noise
            repeat ($urandom_range(4, 1))
                push_frame($urandom_range(15), $urandom_range(COORD_MAX),
                           $urandom_range(COORD_MAX), 1'($urandom_range(1)));
        end
    endtask

    // Hold until every frame is taken and every gesture has come out
    task automatic drain();
        while (frame_q.size() > 0 || s_tvalid || predicted_gestures.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int ph_long[NUM_PHASES];
        int ph_gap[NUM_PHASES];
        int ph_still[NUM_PHASES];
        int ph_dtap[NUM_PHASES];
        int target;

        // Phase 0 runs on the reset thresholds; the others include the extremes
        ph_long  = '{30, 3, 1, 65535, 8};
        ph_gap   = '{15, 2, 0, 65534, 4};
        ph_still = '{2, 0, 255, 7, 3};
        ph_dtap  = '{5, 0, 255, 12, 9};

        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        err_count      = 0;
        cycle_count    = 0;

        cfg_q.long_press_ticks     = LONG_PRESS_RESET;
        cfg_q.double_tap_gap_ticks = DTAP_GAP_RESET;
        cfg_q.still_radius         = STILL_RAD_RESET;
        cfg_q.double_tap_radius    = DTAP_RAD_RESET;
        hold_cnt = 0;
        gap_cnt  = 0;
        win_open = 1'b0;
        anc_x    = '0;
        anc_y    = '0;
        last_g   = G_IDLE;
        prev_cnt = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // Idling pattern: none, sender, receiver, both
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 74; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 74; end
                default: begin src_idle_pct = 20; sink_stall_pct = 20; end
            endcase

            if (ph > 0)
            begin
                write_cfg(REG_LONG_PRESS, ph_long[ph]);
                write_cfg(REG_DTAP_GAP, ph_gap[ph]);
                write_cfg(REG_STILL_RAD, ph_still[ph]);
                write_cfg(REG_DTAP_RAD, ph_dtap[ph]);
            end
            else
            begin
                // Directed frames against the reset thresholds
                push_frame(0, 0, 0, 0);
                push_frame(1, COORD_MAX, COORD_MAX, 0);          // down at far corner
                push_frame(1, COORD_MAX - 1, COORD_MAX - 1, 0);  // move right on radius
                push_frame(0, 0, 0, 0);                          // tap
                push_frame(0, COORD_MAX, 0, 0);                  // gap frame
                push_frame(1, COORD_MAX - 3, COORD_MAX - 2, 0);  // double tap at radius
                push_frame(1, COORD_MAX, COORD_MAX, 0);          // double tap repeats
                push_frame(0, 0, 0, 0);
                push_frame(1, 0, 0, 0);                          // down at origin
                push_frame(1, 2, 1, 0);                          // slide one past radius
                push_frame(1, 0, 0, 0);                          // stray single point
                push_frame(0, 0, 0, 0);
                push_frame(1, 100, 200, 0);
                push_frame(15, 100, 200, 0);                     // most fingers
                push_frame(1, 100, 200, 0);                      // stray after multi
                push_frame(0, 0, 0, 0);
                push_frame(1, 10, COORD_MAX, 0);
                push_frame(1, 10, COORD_MAX, 1);                 // recalc release
                push_frame(0, 0, 0, 0);
                push_frame(1, 16, COORD_MAX, 0);                 // just outside tap radius
                push_frame(0, 0, 0, 0);
                push_frame(2, COORD_MAX, COORD_MAX, 0);          // window closes
                push_frame(1, 16, COORD_MAX, 0);
                push_frame(0, COORD_MAX, COORD_MAX, 1);
            end

            target = frame_q.size() + RANDOM_ITEMS_PER_PHASE;
            while (frame_q.size() < target)
                gen_sequence();
            drain();
        end

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
rtl/core/tgc_pkg.sv
rtl/core/tgc_dist.sv
rtl/core/tgc_core.sv
rtl/core/touch_gesture_classifier.sv
dv/touch_gesture_classifier_tb.sv
